// ===== rtl/qrm_pkg.sv =====
// Package for the quaternion to rotation matrix block.
// Holds the fixed widths, lane count and the sign extension helper.
// No dependencies.
`default_nettype none
package qrm_pkg;
  localparam int IN_W    = 16;
  localparam int PROD_W  = 32;
  localparam int NUM_W   = 35;
  localparam int LEN_W   = 34;
  localparam int MAG_W   = 34;
  localparam int QBITS   = 15;
  localparam int REM_W   = 50;
  localparam int LANES   = 9;
  localparam int NPROD   = 10;
  localparam int OUT_W   = 16;
  localparam logic [QBITS-1:0] ONE_Q14 = 15'd16384;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [NUM_W-1:0]  num_t;

  function automatic num_t ext_prod(input prod_t p);
    ext_prod = num_t'(p);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/quaternion_to_rotation_matrix.sv =====
// Quaternion to 3x3 rotation matrix, fully pipelined.
// Depends on qrm_pkg for widths, types and constants.
//
// Usage: drive in_quat_x/y/z/w (signed Q2.13) with start high; a beat is
// taken at each rising edge where start is high and busy is low. busy is
// high only while rst_n is low and in the cycle after, so a new quaternion
// can enter on every cycle. Each beat yields one result beat on the out_
// ports once it leaves the output register, marked by out_valid for exactly one
// cycle. The nine entries are signed Q1.14 of the normalized quaternion,
// rounded to nearest with ties away from zero. A zero quaternion gives
// the identity with out_degenerate set.
// The pipeline holds three arithmetic stages (products, numerators, dividend
// setup), fifteen restoring division stages (one quotient bit each, all
// nine entries in parallel) and the output register. Throughput is one
// beat per cycle. Reset clears all valid bits; data registers are not
// reset. The receiver cannot stall, so results are never held back.
`default_nettype none
module quaternion_to_rotation_matrix import qrm_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [IN_W-1:0]  in_quat_x,
  input  wire logic signed [IN_W-1:0]  in_quat_y,
  input  wire logic signed [IN_W-1:0]  in_quat_z,
  input  wire logic signed [IN_W-1:0]  in_quat_w,
  output logic                         out_valid,
  output logic signed [OUT_W-1:0]      out_m00,
  output logic signed [OUT_W-1:0]      out_m01,
  output logic signed [OUT_W-1:0]      out_m02,
  output logic signed [OUT_W-1:0]      out_m10,
  output logic signed [OUT_W-1:0]      out_m11,
  output logic signed [OUT_W-1:0]      out_m12,
  output logic signed [OUT_W-1:0]      out_m20,
  output logic signed [OUT_W-1:0]      out_m21,
  output logic signed [OUT_W-1:0]      out_m22,
  output logic                         out_degenerate
);

  logic busy_r;
  logic in_acc;

  logic  v1_r;
  prod_t p_r [NPROD];

  logic             v2_r;
  logic [LEN_W-1:0] len_r;
  num_t             num_r [LANES];

  logic             vd_r  [QBITS+1];
  logic             dg_r  [QBITS+1];
  logic [MAG_W-1:0] den_r [QBITS+1];
  logic [REM_W-1:0] rem_r [QBITS+1][LANES];
  logic [QBITS-1:0] q_r   [QBITS+1][LANES];
  logic             ng_r  [QBITS+1][LANES];

  logic [REM_W-1:0] rem_nxt [QBITS][LANES];
  logic [QBITS-1:0] q_nxt   [QBITS][LANES];

  logic [REM_W-1:0] rem0_nxt [LANES];
  logic             ng0_nxt  [LANES];

  logic                    out_valid_r;
  logic                    out_dg_r;
  logic signed [OUT_W-1:0] m_r   [LANES];
  logic signed [OUT_W-1:0] m_nxt [LANES];

  assign in_acc = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  // Stage 1: the ten pairwise products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
    end
    p_r[0] <= prod_t'(in_quat_x) * prod_t'(in_quat_x);
    p_r[1] <= prod_t'(in_quat_y) * prod_t'(in_quat_y);
    p_r[2] <= prod_t'(in_quat_z) * prod_t'(in_quat_z);
    p_r[3] <= prod_t'(in_quat_w) * prod_t'(in_quat_w);
    p_r[4] <= prod_t'(in_quat_x) * prod_t'(in_quat_y);
    p_r[5] <= prod_t'(in_quat_x) * prod_t'(in_quat_z);
    p_r[6] <= prod_t'(in_quat_x) * prod_t'(in_quat_w);
    p_r[7] <= prod_t'(in_quat_y) * prod_t'(in_quat_z);
    p_r[8] <= prod_t'(in_quat_y) * prod_t'(in_quat_w);
    p_r[9] <= prod_t'(in_quat_z) * prod_t'(in_quat_w);
  end

  // Stage 2: squared length and the nine numerators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    len_r <= LEN_W'(p_r[0][PROD_W-2:0]) + LEN_W'(p_r[1][PROD_W-2:0])
           + LEN_W'(p_r[2][PROD_W-2:0]) + LEN_W'(p_r[3][PROD_W-2:0]);
    num_r[0] <= ext_prod(p_r[0]) + ext_prod(p_r[3]) - ext_prod(p_r[1]) - ext_prod(p_r[2]);
    num_r[1] <= (ext_prod(p_r[4]) + ext_prod(p_r[9])) <<< 1;
    num_r[2] <= (ext_prod(p_r[5]) - ext_prod(p_r[8])) <<< 1;
    num_r[3] <= (ext_prod(p_r[4]) - ext_prod(p_r[9])) <<< 1;
    num_r[4] <= ext_prod(p_r[1]) + ext_prod(p_r[3]) - ext_prod(p_r[0]) - ext_prod(p_r[2]);
    num_r[5] <= (ext_prod(p_r[7]) + ext_prod(p_r[6])) <<< 1;
    num_r[6] <= (ext_prod(p_r[5]) + ext_prod(p_r[8])) <<< 1;
    num_r[7] <= (ext_prod(p_r[7]) - ext_prod(p_r[6])) <<< 1;
    num_r[8] <= ext_prod(p_r[2]) + ext_prod(p_r[3]) - ext_prod(p_r[0]) - ext_prod(p_r[1]);
  end

  // Stage 3: sign and magnitude; the dividend carries the rounding half.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ng0_nxt[l]  = num_r[l][NUM_W-1];
      rem0_nxt[l] = (REM_W'(ng0_nxt[l] ? MAG_W'(-num_r[l]) : MAG_W'(num_r[l])) << QBITS)
                  + REM_W'(len_r);
    end
  end

  // Division stages: one quotient bit per stage, divisor is twice the length.
  always_comb begin
    for (int s = 0; s < QBITS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_r[s][l] >= (REM_W'({den_r[s], 1'b0}) << (QBITS-1-s))) begin
          rem_nxt[s][l] = rem_r[s][l] - (REM_W'({den_r[s], 1'b0}) << (QBITS-1-s));
          q_nxt[s][l]   = {q_r[s][l][QBITS-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = rem_r[s][l];
          q_nxt[s][l]   = {q_r[s][l][QBITS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= QBITS; s++) begin
        vd_r[s] <= 1'b0;
      end
    end else begin
      vd_r[0] <= v2_r;
      for (int s = 0; s < QBITS; s++) begin
        vd_r[s+1] <= vd_r[s];
      end
    end
    dg_r[0]  <= (len_r == '0);
    den_r[0] <= len_r;
    for (int l = 0; l < LANES; l++) begin
      rem_r[0][l] <= rem0_nxt[l];
      q_r[0][l]   <= '0;
      ng_r[0][l]  <= ng0_nxt[l];
    end
    for (int s = 0; s < QBITS; s++) begin
      dg_r[s+1]  <= dg_r[s];
      den_r[s+1] <= den_r[s];
      for (int l = 0; l < LANES; l++) begin
        rem_r[s+1][l] <= rem_nxt[s][l];
        q_r[s+1][l]   <= q_nxt[s][l];
        ng_r[s+1][l]  <= ng_r[s][l];
      end
    end
  end

  // Output stage: apply sign, or substitute the identity.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (dg_r[QBITS]) begin
        m_nxt[l] = (l % 4 == 0) ? OUT_W'(ONE_Q14) : '0;
      end else if (ng_r[QBITS][l]) begin
        m_nxt[l] = -OUT_W'(q_r[QBITS][l]);
      end else begin
        m_nxt[l] = OUT_W'(q_r[QBITS][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vd_r[QBITS];
    end
    out_dg_r <= dg_r[QBITS];
    for (int l = 0; l < LANES; l++) begin
      m_r[l] <= m_nxt[l];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_degenerate = out_dg_r;
  assign out_m00 = m_r[0];
  assign out_m01 = m_r[1];
  assign out_m02 = m_r[2];
  assign out_m10 = m_r[3];
  assign out_m11 = m_r[4];
  assign out_m12 = m_r[5];
  assign out_m20 = m_r[6];
  assign out_m21 = m_r[7];
  assign out_m22 = m_r[8];

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r[QBITS] |=> out_valid)
    else $error("division result beat was not presented");

  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_m00 == 16'sd16384 && out_m11 == 16'sd16384
      && out_m22 == 16'sd16384 && out_m01 == '0 && out_m21 == '0)
    else $error("degenerate beat is not the identity");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_m00 <= 16'sd16384 && out_m00 >= -16'sd16384
      && out_m12 <= 16'sd16384 && out_m12 >= -16'sd16384)
    else $error("matrix entry out of range");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && len_r == '0 |=> dg_r[0])
    else $error("zero length not flagged");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for quaternion_to_rotation_matrix.
// Drives quaternions through the command port, predicts each matrix and compares it.
// Depends on qrm_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import qrm_pkg::*;

  typedef struct {
    logic signed [15:0] m [9];
    logic               degen;
  } rot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [15:0] in_quat_x = '0, in_quat_y = '0, in_quat_z = '0, in_quat_w = '0;
  wire busy, out_valid, out_degenerate;
  wire signed [15:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  wire signed [15:0] out_m20, out_m21, out_m22;

  rot_t expected_mats [$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int degen_seen = 0;
  longint cycles = 0;

  always #1 clk = ~clk;

  quaternion_to_rotation_matrix uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_quat_x(in_quat_x), .in_quat_y(in_quat_y),
    .in_quat_z(in_quat_z), .in_quat_w(in_quat_w),
    .out_valid(out_valid),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m10(out_m10), .out_m11(out_m11), .out_m12(out_m12),
    .out_m20(out_m20), .out_m21(out_m21), .out_m22(out_m22),
    .out_degenerate(out_degenerate)
  );

  function automatic logic signed [15:0] q14_ratio(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag * 16384 + den) / (2 * den);
    if (q > 16384) q = 16384;
    return (num < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic rot_t quat_to_matrix(longint x, longint y, longint z, longint w);
    rot_t r;
    longint l2;
    l2 = x*x + y*y + z*z + w*w;
    if (l2 == 0) begin
      foreach (r.m[i]) r.m[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
      r.degen = 1'b1;
    end else begin
      r.m[0] = q14_ratio(x*x + w*w - y*y - z*z, l2);
      r.m[1] = q14_ratio(2 * (x*y + z*w), l2);
      r.m[2] = q14_ratio(2 * (x*z - y*w), l2);
      r.m[3] = q14_ratio(2 * (x*y - z*w), l2);
      r.m[4] = q14_ratio(y*y + w*w - x*x - z*z, l2);
      r.m[5] = q14_ratio(2 * (y*z + x*w), l2);
      r.m[6] = q14_ratio(2 * (x*z + y*w), l2);
      r.m[7] = q14_ratio(2 * (y*z - x*w), l2);
      r.m[8] = q14_ratio(z*z + w*w - x*x - y*y, l2);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] w,
                           bit gaps = 1);
    start <= 1'b1;
    in_quat_x <= x;
    in_quat_y <= y;
    in_quat_z <= z;
    in_quat_w <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_mats.push_back(quat_to_matrix($signed(x), $signed(y), $signed(z), $signed(w)));
    beats_sent++;
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      idle_gap();
    end
  endtask

  always @(posedge clk) begin
    rot_t e;
    logic signed [15:0] got [9];
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      got = '{out_m00, out_m01, out_m02, out_m10, out_m11, out_m12,
              out_m20, out_m21, out_m22};
      if (expected_mats.size() == 0) begin
        $error("result beat with no quaternion outstanding");
        errors++;
      end else begin
        e = expected_mats.pop_front();
        beats_checked++;
        if (e.degen) degen_seen++;
        foreach (got[i])
          if (got[i] !== e.m[i]) begin
            $error("m%0d%0d expected %0d got %0d", i / 3, i % 3, e.m[i], got[i]);
            errors++;
          end
        if (out_degenerate !== e.degen) begin
          $error("degenerate expected %0b got %0b", e.degen, out_degenerate);
          errors++;
        end
      end
    end
  end

  always @(posedge clk)
    if (cycles > 200000) begin
      $display("[FAIL] regression broken");
      $finish;
    end

  task automatic test_directed();
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h2000);
    send_quat(16'h2000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h2000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h2000, 16'h0000);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0001, 16'h0001, 16'h0000, 16'h0000);
    send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0000);
    send_quat(16'h0001, 16'h0002, 16'h0003, 16'h0004);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0001);
    send_quat(16'h1000, 16'hF000, 16'h1000, 16'hF000);
    send_quat(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0);
    send_quat(16'h0003, 16'h0001, 16'h0000, 16'h0000);
  endtask

  task automatic test_random();
    logic [15:0] v [4];
    for (int n = 0; n < 900; n++) begin
      foreach (v[i])
        case ($urandom_range(0, 5))
          0: v[i] = 16'($signed($urandom_range(0, 6)) - 3);
          1: v[i] = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7FFF;
          default: v[i] = 16'($urandom);
        endcase
      if ($urandom_range(0, 40) == 0) v = '{16'h0, 16'h0, 16'h0, 16'h0};
      send_quat(v[0], v[1], v[2], v[3], n % 200 >= 50);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    start <= 1'b0;
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    $display("Sent %0d quaternions, checked %0d matrices (%0d zero-length).",
             beats_sent, beats_checked, degen_seen);
    if (errors == 0 && expected_mats.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/qrm_pkg.sv
rtl/quaternion_to_rotation_matrix.sv
tb/tb.sv
